// ----- src/slpsq_pkg.sv -----
// ----------------------------------------------------------------------------
// slpsq_pkg
// Shared types and constants for the status LED pattern sequencer.
// ----------------------------------------------------------------------------
package slpsq_pkg;

  // field widths fixed by the interface
  localparam int TICK_W    = 16;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;

  // event codes
  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_CONNECT    = 2'd1,
    ACT_DISCONNECT = 2'd2,
    ACT_BATTERY    = 2'd3
  } action_t;

  // sequencer modes as seen on the result channel
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ADV   = 3'd1,
    MODE_BATT  = 3'd2,
    MODE_PULSE = 3'd3,
    MODE_WAIT  = 3'd4
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADV_ON       = 3'd0,
    CFG_ADV_GAP      = 3'd1,
    CFG_ADV_INTERVAL = 3'd2,
    CFG_BATT_ON      = 3'd3,
    CFG_BATT_OFF     = 3'd4,
    CFG_CONN_ON      = 3'd5,
    CFG_HIGH_PCT     = 3'd6,
    CFG_LOW_PCT      = 3'd7
  } cfg_idx_t;

  // configuration reset values
  localparam logic [TICK_W-1:0] RST_ADV_ON       = 16'd100;
  localparam logic [TICK_W-1:0] RST_ADV_GAP      = 16'd100;
  localparam logic [TICK_W-1:0] RST_ADV_INTERVAL = 16'd2000;
  localparam logic [TICK_W-1:0] RST_BATT_ON      = 16'd200;
  localparam logic [TICK_W-1:0] RST_BATT_OFF     = 16'd200;
  localparam logic [TICK_W-1:0] RST_CONN_ON      = 16'd1000;
  localparam logic [PCT_W-1:0]  RST_HIGH_PCT     = 7'd70;
  localparam logic [PCT_W-1:0]  RST_LOW_PCT      = 7'd30;

  // battery blink counts
  localparam logic [1:0] BLINKS_HIGH = 2'd3;
  localparam logic [1:0] BLINKS_MID  = 2'd2;
  localparam logic [1:0] BLINKS_LOW  = 2'd1;

  // all configuration registers
  typedef struct packed {
    logic [TICK_W-1:0] adv_on;
    logic [TICK_W-1:0] adv_gap;
    logic [TICK_W-1:0] adv_interval;
    logic [TICK_W-1:0] batt_on;
    logic [TICK_W-1:0] batt_off;
    logic [TICK_W-1:0] conn_on;
    logic [PCT_W-1:0]  high_pct;
    logic [PCT_W-1:0]  low_pct;
  } cfg_regs_t;

  // sequencer control state, the phase timer travels beside it
  typedef struct packed {
    logic       led;
    logic       link;
    mode_t      mode;
    logic [1:0] burst;
    logic [1:0] batt_left;
  } seq_state_t;

endpackage

// ----- src/slpsq_cfg.sv -----
// ----------------------------------------------------------------------------
// slpsq_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module slpsq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slpsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slpsq_pkg::TICK_W-1:0]    cfg_data,
  output slpsq_pkg::cfg_regs_t            regs
);
  import slpsq_pkg::*;

  cfg_regs_t regs_r;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.adv_on       <= RST_ADV_ON;
      regs_r.adv_gap      <= RST_ADV_GAP;
      regs_r.adv_interval <= RST_ADV_INTERVAL;
      regs_r.batt_on      <= RST_BATT_ON;
      regs_r.batt_off     <= RST_BATT_OFF;
      regs_r.conn_on      <= RST_CONN_ON;
      regs_r.high_pct     <= RST_HIGH_PCT;
      regs_r.low_pct      <= RST_LOW_PCT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ADV_ON:       regs_r.adv_on       <= cfg_data;
        CFG_ADV_GAP:      regs_r.adv_gap      <= cfg_data;
        CFG_ADV_INTERVAL: regs_r.adv_interval <= cfg_data;
        CFG_BATT_ON:      regs_r.batt_on      <= cfg_data;
        CFG_BATT_OFF:     regs_r.batt_off     <= cfg_data;
        CFG_CONN_ON:      regs_r.conn_on      <= cfg_data;
        CFG_HIGH_PCT:     regs_r.high_pct     <= cfg_data[PCT_W-1:0];
        CFG_LOW_PCT:      regs_r.low_pct      <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/slpsq_step.sv -----
// ----------------------------------------------------------------------------
// slpsq_step
// Next-state logic: applies one event to the sequencer state in one pass.
// ----------------------------------------------------------------------------
module slpsq_step #(
  parameter int ADV_BLINKS = 2,
  parameter int TIMER_BITS = 16
) (
  input  slpsq_pkg::action_t             action,
  input  logic                           connect_error,
  input  logic [slpsq_pkg::PCT_W-1:0]    battery_percent,
  input  slpsq_pkg::cfg_regs_t           regs,
  input  slpsq_pkg::seq_state_t          st,
  input  logic [TIMER_BITS-1:0]          timer,
  output slpsq_pkg::seq_state_t          st_nxt,
  output logic [TIMER_BITS-1:0]          timer_nxt
);
  import slpsq_pkg::*;

  localparam int WIDE_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
  localparam logic [WIDE_W-1:0] TIMER_CAP = WIDE_W'({TIMER_BITS{1'b1}});

  logic                  load_en;
  logic                  clear_en;
  logic                  dec_en;
  logic [TICK_W-1:0]     load_ticks;
  logic [WIDE_W-1:0]     load_ext;
  logic [TIMER_BITS-1:0] load_val;
  logic [1:0]            burst_inc;
  logic [1:0]            left_dec;
  logic [1:0]            blinks;

  assign burst_inc = st.burst + 2'd1;
  assign left_dec  = st.batt_left - 2'd1;

  // blink count from charge thresholds
  always_comb begin
    priority if (battery_percent > regs.high_pct) begin
      blinks = BLINKS_HIGH;
    end else if (battery_percent > regs.low_pct) begin
      blinks = BLINKS_MID;
    end else begin
      blinks = BLINKS_LOW;
    end
  end

  // event and phase-end handling
  always_comb begin
    st_nxt     = st;
    load_en    = 1'b0;
    clear_en   = 1'b0;
    dec_en     = 1'b0;
    load_ticks = regs.adv_on;
    unique case (action)
      ACT_TICK: begin
        if (st.mode != MODE_IDLE) begin
          if (timer <= TIMER_BITS'(1)) begin
            unique case (st.mode)
              MODE_ADV: begin
                load_en = 1'b1;
                if (st.led) begin
                  st_nxt.led = 1'b0;
                  if (burst_inc < 2'(ADV_BLINKS)) begin
                    st_nxt.burst = burst_inc;
                    load_ticks   = regs.adv_gap;
                  end else begin
                    st_nxt.burst = 2'd0;
                    load_ticks   = regs.adv_interval;
                  end
                end else begin
                  st_nxt.led = 1'b1;
                  load_ticks = regs.adv_on;
                end
              end
              MODE_BATT: begin
                if (st.led) begin
                  st_nxt.led = 1'b0;
                  load_en    = 1'b1;
                  load_ticks = regs.batt_off;
                end else begin
                  st_nxt.batt_left = left_dec;
                  if (left_dec != 2'd0) begin
                    st_nxt.led = 1'b1;
                    load_en    = 1'b1;
                    load_ticks = regs.batt_on;
                  end else if (!st.link) begin
                    st_nxt.mode = MODE_WAIT;
                    load_en     = 1'b1;
                    load_ticks  = regs.adv_interval;
                  end else begin
                    st_nxt.mode = MODE_IDLE;
                    clear_en    = 1'b1;
                  end
                end
              end
              MODE_PULSE: begin
                st_nxt.led  = 1'b0;
                st_nxt.mode = MODE_IDLE;
                clear_en    = 1'b1;
              end
              MODE_WAIT: begin
                // restart advertising
                st_nxt.mode  = MODE_ADV;
                st_nxt.burst = 2'd0;
                st_nxt.led   = 1'b1;
                load_en      = 1'b1;
                load_ticks   = regs.adv_on;
              end
              default: ;
            endcase
          end else begin
            dec_en = 1'b1;
          end
        end
      end
      ACT_CONNECT: begin
        if (!connect_error) begin
          st_nxt.link = 1'b1;
          if (st.mode != MODE_BATT) begin
            st_nxt.mode  = MODE_PULSE;
            st_nxt.burst = 2'd0;
            st_nxt.led   = 1'b1;
            load_en      = 1'b1;
            load_ticks   = regs.conn_on;
          end
        end
      end
      ACT_DISCONNECT: begin
        st_nxt.link = 1'b0;
        if (st.mode != MODE_BATT) begin
          st_nxt.mode  = MODE_ADV;
          st_nxt.burst = 2'd0;
          st_nxt.led   = 1'b1;
          load_en      = 1'b1;
          load_ticks   = regs.adv_on;
        end
      end
      ACT_BATTERY: begin
        if (st.mode != MODE_BATT) begin
          st_nxt.mode      = MODE_BATT;
          st_nxt.burst     = 2'd0;
          st_nxt.batt_left = blinks;
          st_nxt.led       = 1'b1;
          load_en          = 1'b1;
          load_ticks       = regs.batt_on;
        end
      end
      default: ;
    endcase
  end

  // saturate the load to the timer width
  assign load_ext = WIDE_W'(load_ticks);
  assign load_val = (load_ext > TIMER_CAP) ? TIMER_CAP[TIMER_BITS-1:0]
                                           : load_ext[TIMER_BITS-1:0];

  // phase timer update
  always_comb begin
    priority if (load_en) begin
      timer_nxt = load_val;
    end else if (clear_en) begin
      timer_nxt = '0;
    end else if (dec_en) begin
      timer_nxt = timer - TIMER_BITS'(1);
    end else begin
      timer_nxt = timer;
    end
  end

endmodule

// ----- src/status_led_pattern_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer_core
// Event-driven status LED sequencer: advertising bursts, battery level
// blinks and a connect pulse, timed by tick events.
// ----------------------------------------------------------------------------
// Takes one event per clock while in_stall is low and gives one result per
// event: the event is held in an input register, the next-state logic works
// on it in one pass, and the LED level, mode and link flag land in the
// result register together with the updated sequencer state. A held-up
// result register stops the input only once the input register is also full,
// so the block keeps one event in flight behind a waiting result.
// Configuration writes are taken at once on every cycle.
module status_led_pattern_sequencer_core #(
  parameter int ADV_BLINKS = 2,
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // event channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic                            in_connect_error,
  input  logic [slpsq_pkg::PCT_W-1:0]     in_battery_percent,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_led_on,
  output logic [2:0]                      out_mode,
  output logic                            out_link_up,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slpsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slpsq_pkg::TICK_W-1:0]    cfg_data
);
  import slpsq_pkg::*;

  cfg_regs_t             regs;
  seq_state_t            st_r;
  seq_state_t            st_nxt;
  logic [TIMER_BITS-1:0] timer_r;
  logic [TIMER_BITS-1:0] timer_nxt;
  logic                  in_v_r;
  action_t               in_action_r;
  logic                  in_err_r;
  logic [PCT_W-1:0]      in_pct_r;
  logic                  out_v_r;
  logic                  out_led_r;
  mode_t                 out_mode_r;
  logic                  out_link_r;
  logic                  advance;

  // configuration registers
  slpsq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // next-state logic
  slpsq_step #(
    .ADV_BLINKS (ADV_BLINKS),
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .action          (in_action_r),
    .connect_error   (in_err_r),
    .battery_percent (in_pct_r),
    .regs            (regs),
    .st              (st_r),
    .timer           (timer_r),
    .st_nxt          (st_nxt),
    .timer_nxt       (timer_nxt)
  );

  // handshake: the held event moves on when the result register is free
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action_r <= action_t'(in_action);
      in_err_r    <= in_connect_error;
      in_pct_r    <= in_battery_percent;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.led       <= 1'b0;
      st_r.link      <= 1'b0;
      st_r.mode      <= MODE_IDLE;
      st_r.burst     <= 2'd0;
      st_r.batt_left <= 2'd0;
      timer_r        <= '0;
    end else if (advance) begin
      st_r    <= st_nxt;
      timer_r <= timer_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led_r  <= st_nxt.led;
      out_mode_r <= st_nxt.mode;
      out_link_r <= st_nxt.link;
    end
  end

  assign out_valid   = out_v_r;
  assign out_led_on  = out_led_r;
  assign out_mode    = out_mode_r;
  assign out_link_up = out_link_r;

  // a waiting result always mirrors the sequencer state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_mode_r == st_r.mode && out_led_r == st_r.led &&
                 out_link_r == st_r.link))
    else $error("result register out of step with sequencer state");

  // idle means LED off and timer cleared
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_IDLE |-> (!st_r.led && timer_r == '0))
    else $error("idle with LED on or timer running");

  // the connect pulse keeps the LED on until it ends
  a_pulse_led: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_PULSE |-> st_r.led)
    else $error("connect pulse with LED off");

  // burst counter stays within one burst
  a_burst_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.burst < 2'(ADV_BLINKS))
    else $error("advertising burst count out of range");

endmodule
